@@ rtl/msms_pkg.sv @@
package msms_pkg;

  localparam int TIMER_W = 24;
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  localparam int REPLY_CAPACITY = 256;
  localparam int FILL_W = $clog2(REPLY_CAPACITY);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(REPLY_CAPACITY - 1);

  localparam int NKW = 6;
  localparam int KW_OK = 0;
  localparam int KW_PROMPT = 1;
  localparam int KW_CMGS = 2;
  localparam int KW_ERROR = 3;
  localparam int KW_REG_HOME = 4;
  localparam int KW_REG_ROAM = 5;

  localparam logic [3:0] PH_BOOT = 4'd0;
  localparam logic [3:0] PH_PROBE = 4'd1;
  localparam logic [3:0] PH_PROBE_WAIT = 4'd2;
  localparam logic [3:0] PH_TEXT = 4'd3;
  localparam logic [3:0] PH_TEXT_WAIT = 4'd4;
  localparam logic [3:0] PH_READY = 4'd5;
  localparam logic [3:0] PH_HEADER = 4'd6;
  localparam logic [3:0] PH_PROMPT_WAIT = 4'd7;
  localparam logic [3:0] PH_BODY = 4'd8;
  localparam logic [3:0] PH_SEND_WAIT = 4'd9;
  localparam logic [3:0] PH_REG = 4'd10;
  localparam logic [3:0] PH_REG_WAIT = 4'd11;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_PROBE = 3'd1;
  localparam logic [2:0] ACT_TEXT = 3'd2;
  localparam logic [2:0] ACT_REG = 3'd3;
  localparam logic [2:0] ACT_HEADER = 3'd4;
  localparam logic [2:0] ACT_BODY = 3'd5;

  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_CONFIRMED = 2'd1;
  localparam logic [1:0] OUT_ERROR = 2'd2;
  localparam logic [1:0] OUT_TIMEOUT = 2'd3;

  localparam logic [2:0] REG_BOOT_WAIT = 3'd0;
  localparam logic [2:0] REG_REPLY_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_PROMPT_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_SEND_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_INTERVAL = 3'd4;

  typedef struct packed {
    logic [TIMER_W-1:0] boot_wait_ms;
    logic [TIMER_W-1:0] reply_timeout_ms;
    logic [TIMER_W-1:0] prompt_timeout_ms;
    logic [TIMER_W-1:0] send_timeout_ms;
    logic [TIMER_W-1:0] message_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] phase;
    logic [1:0] outcome;
  } res_t;

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0: kw_len = 3'd2;
      3'd1: kw_len = 3'd1;
      3'd2: kw_len = 3'd5;
      3'd3: kw_len = 3'd5;
      3'd4: kw_len = 3'd3;
      3'd5: kw_len = 3'd3;
      default: kw_len = 3'd1;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
    logic [39:0] text;
    case (k)
      3'd0: text = 40'h00_00_00_4B_4F;
      3'd1: text = 40'h00_00_00_00_3E;
      3'd2: text = 40'h53_47_4D_43_2B;
      3'd3: text = 40'h52_4F_52_52_45;
      3'd4: text = 40'h00_00_31_2C_30;
      3'd5: text = 40'h00_00_35_2C_30;
      default: text = 40'h0;
    endcase
    case (p)
      3'd0: kw_char = text[7:0];
      3'd1: kw_char = text[15:8];
      3'd2: kw_char = text[23:16];
      3'd3: kw_char = text[31:24];
      3'd4: kw_char = text[39:32];
      default: kw_char = 8'h00;
    endcase
  endfunction

endpackage

@@ rtl/msms_match.sv @@
module msms_match import msms_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     rx_byte,
  input  logic           clear,
  output logic [NKW-1:0] found
);

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              stopped;
  logic              stopped_next;
  logic [2:0]        progress [NKW];
  logic [2:0]        progress_next [NKW];
  logic [NKW-1:0]    found_next;

  always_comb begin
    logic [2:0] p;
    p = 3'd0;
    fill_next = fill;
    stopped_next = stopped;
    found_next = found;
    for (int k = 0; k < NKW; k++) begin
      progress_next[k] = progress[k];
    end
    if (clear) begin
      fill_next = '0;
      stopped_next = 1'b0;
      found_next = '0;
      for (int k = 0; k < NKW; k++) begin
        progress_next[k] = 3'd0;
      end
    end else if (take && !stopped && fill != FILL_MAX) begin
      fill_next = fill + 1'b1;
      if (rx_byte == 8'h00) begin
        stopped_next = 1'b1;
      end else begin
        for (int k = 0; k < NKW; k++) begin
          p = progress[k];
          if (p < kw_len(3'(k)) && kw_char(3'(k), p) == rx_byte) begin
            p = p + 3'd1;
          end else if (kw_char(3'(k), 3'd0) == rx_byte) begin
            p = 3'd1;
          end else begin
            p = 3'd0;
          end
          if (p >= kw_len(3'(k))) begin
            found_next[k] = 1'b1;
            p = 3'd0;
          end
          progress_next[k] = p;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      stopped <= 1'b0;
      found <= '0;
      for (int k = 0; k < NKW; k++) begin
        progress[k] <= 3'd0;
      end
    end else begin
      fill <= fill_next;
      stopped <= stopped_next;
      found <= found_next;
      for (int k = 0; k < NKW; k++) begin
        progress[k] <= progress_next[k];
      end
    end
  end

endmodule

@@ rtl/msms_seq.sv @@
module msms_seq import msms_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           tick,
  input  logic           step_enable,
  input  logic [NKW-1:0] found,
  input  cfg_t           cfg,
  output logic           clear,
  output res_t           res
);

  logic [3:0]         phase;
  logic [3:0]         phase_next;
  logic [TIMER_W-1:0] elapsed;
  logic [TIMER_W-1:0] elapsed_next;
  logic [TIMER_W-1:0] since;
  logic [TIMER_W-1:0] since_next;
  logic [TIMER_W-1:0] elapsed_inc;
  logic [TIMER_W-1:0] since_inc;

  assign elapsed_inc = (elapsed == TIMER_MAX) ? elapsed : elapsed + 1'b1;
  assign since_inc = (since == TIMER_MAX) ? since : since + 1'b1;

  always_comb begin
    phase_next = phase;
    elapsed_next = elapsed;
    since_next = since;
    clear = 1'b0;
    res.action = ACT_NONE;
    res.outcome = OUT_NONE;
    if (tick) begin
      elapsed_next = elapsed_inc;
      since_next = since_inc;
      if (step_enable) begin
        case (phase)
          PH_BOOT: begin
            if (elapsed_inc > cfg.boot_wait_ms) phase_next = PH_PROBE;
          end
          PH_PROBE: begin
            res.action = ACT_PROBE;
            phase_next = PH_PROBE_WAIT;
            elapsed_next = '0;
          end
          PH_PROBE_WAIT: begin
            if (found[KW_OK]) begin
              clear = 1'b1;
              phase_next = PH_TEXT;
            end else if (elapsed_inc > cfg.reply_timeout_ms) begin
              phase_next = PH_PROBE;
            end
          end
          PH_TEXT: begin
            res.action = ACT_TEXT;
            phase_next = PH_TEXT_WAIT;
            elapsed_next = '0;
          end
          PH_TEXT_WAIT: begin
            if (found[KW_OK]) begin
              clear = 1'b1;
              phase_next = PH_REG;
            end else if (elapsed_inc > cfg.reply_timeout_ms) begin
              phase_next = PH_TEXT;
            end
          end
          PH_READY: begin
            if (since_inc >= cfg.message_interval_ms) begin
              since_next = '0;
              phase_next = PH_HEADER;
            end
          end
          PH_HEADER: begin
            clear = 1'b1;
            res.action = ACT_HEADER;
            phase_next = PH_PROMPT_WAIT;
            elapsed_next = '0;
          end
          PH_PROMPT_WAIT: begin
            if (found[KW_PROMPT]) begin
              clear = 1'b1;
              phase_next = PH_BODY;
            end else if (elapsed_inc > cfg.prompt_timeout_ms) begin
              phase_next = PH_READY;
              res.outcome = OUT_TIMEOUT;
            end
          end
          PH_BODY: begin
            clear = 1'b1;
            res.action = ACT_BODY;
            phase_next = PH_SEND_WAIT;
            elapsed_next = '0;
          end
          PH_SEND_WAIT: begin
            if (found[KW_CMGS]) begin
              clear = 1'b1;
              phase_next = PH_READY;
              res.outcome = OUT_CONFIRMED;
            end else if (found[KW_ERROR]) begin
              clear = 1'b1;
              phase_next = PH_READY;
              res.outcome = OUT_ERROR;
            end else if (elapsed_inc > cfg.send_timeout_ms) begin
              phase_next = PH_READY;
              res.outcome = OUT_TIMEOUT;
            end
          end
          PH_REG: begin
            res.action = ACT_REG;
            phase_next = PH_REG_WAIT;
            elapsed_next = '0;
          end
          PH_REG_WAIT: begin
            if (found[KW_REG_HOME] || found[KW_REG_ROAM]) begin
              clear = 1'b1;
              phase_next = PH_READY;
            end else if (elapsed_inc > cfg.reply_timeout_ms) begin
              phase_next = PH_REG;
            end
          end
          default: begin
            phase_next = PH_BOOT;
          end
        endcase
      end
    end
    res.phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BOOT;
      elapsed <= '0;
      since <= '0;
    end else begin
      phase <= phase_next;
      elapsed <= elapsed_next;
      since <= since_next;
    end
  end

endmodule

@@ rtl/modem_sms_command_sequencer.sv @@
// Text-message sequencer for a cellular modem. Each input item is either a
// one-millisecond tick that steps the sequencer or a received modem byte that
// feeds the keyword matchers, and each item yields exactly one result item
// in the cycle after it is accepted. The block takes one item per clock cycle
// whenever the single output register, which is the only stage, is empty or
// its result is taken in the same cycle. Configuration registers are written
// through their own port, which is always ready, and should only be written
// while no item is in flight.
module modem_sms_command_sequencer import msms_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [7:0]         rx_byte,
  input  logic               step_enable,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         action,
  output logic [3:0]         phase,
  output logic [1:0]         outcome,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [TIMER_W-1:0] cfg_data
);

  cfg_t           cfg;
  logic           accept;
  logic           clear;
  logic [NKW-1:0] found;
  res_t           res;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_wait_ms <= TIMER_W'(10000);
      cfg.reply_timeout_ms <= TIMER_W'(2000);
      cfg.prompt_timeout_ms <= TIMER_W'(5000);
      cfg.send_timeout_ms <= TIMER_W'(15000);
      cfg.message_interval_ms <= TIMER_W'(60000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOOT_WAIT: cfg.boot_wait_ms <= cfg_data;
        REG_REPLY_TIMEOUT: cfg.reply_timeout_ms <= cfg_data;
        REG_PROMPT_TIMEOUT: cfg.prompt_timeout_ms <= cfg_data;
        REG_SEND_TIMEOUT: cfg.send_timeout_ms <= cfg_data;
        REG_INTERVAL: cfg.message_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  msms_match u_match (
    .clk     (clk),
    .rst     (rst),
    .take    (accept && command),
    .rx_byte (rx_byte),
    .clear   (clear),
    .found   (found)
  );

  msms_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .tick        (accept && !command),
    .step_enable (step_enable),
    .found       (found),
    .cfg         (cfg),
    .clear       (clear),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action <= res.action;
      phase <= res.phase;
      outcome <= res.outcome;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> phase <= PH_REG_WAIT)
    else $error("result phase out of range");

  a_action_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (action == ACT_NONE || outcome == OUT_NONE))
    else $error("action and outcome in the same result");

  a_byte_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && command |=> out_valid && action == ACT_NONE && outcome == OUT_NONE
      && phase == $past(u_seq.phase))
    else $error("received byte item changed the sequencer");

endmodule
